@@ rtl/mp2d_pkg.sv @@
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the streaming 2D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

  localparam int CFG_BITS  = 11;
  localparam int DIM_BITS  = 11;
  localparam int WIN_BITS  = 5;
  localparam int POS_BITS  = 10;
  localparam int IWIN_BITS = 4;

  localparam logic [DIM_BITS-1:0] DIM_LIMIT = 11'd1024;
  localparam logic [WIN_BITS-1:0] WIN_LIMIT = 5'd16;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 11'd8;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 5'd4;

  // Depth of the result queue in front of the output port.
  localparam int          OQ_DEPTH = 3;
  localparam logic [1:0]  OQ_LAST  = 2'd2;
  localparam logic [2:0]  OQ_FULL  = 3'd3;

  // Position and end-of-frame flag that travel with a pooled result.
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } res_meta_t;

endpackage

@@ rtl/mp2d_ofifo.sv @@
// ----------------------------------------------------------------------------
// mp2d_ofifo
// Three-entry result queue that decouples the pooling pipeline from the
// output stall.
// ----------------------------------------------------------------------------
module mp2d_ofifo import mp2d_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic signed [DATA_BITS-1:0] push_data,
  input  res_meta_t                   push_meta,
  output logic [1:0]                  count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_BITS-1:0] out_data,
  output res_meta_t                   out_meta
);

  logic signed [DATA_BITS-1:0] data_r [OQ_DEPTH];
  res_meta_t                   meta_r [OQ_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = data_r[rd_ptr_r];
  assign out_meta  = meta_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_LAST) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_LAST) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
      meta_r[wr_ptr_r] <= push_meta;
    end
  end

endmodule

@@ rtl/max_pool_2d_stream.sv @@
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Non-overlapping 2D max pooling over a raster pixel stream, with one running
// maximum per pooled column held in a line memory.
// ----------------------------------------------------------------------------
// A window's last pixel is registered in stage one (line memory read), then
// compared and written back into the result queue, which presents the beat.
// One pixel per cycle unless stalled; same-column read-after-write is bypassed.
// Reset clears counters and the result queue and loads 8 x 8 frames with a
// window of 4; the line memory is not cleared, as the first pixel of each
// window ignores the value it reads.
module max_pool_2d_stream import mp2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PIXEL_BITS-1:0] out_pooled_max,
  output logic [POS_BITS-1:0]          out_pool_row,
  output logic [POS_BITS-1:0]          out_pool_col,
  output logic                         out_frame_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Clamped configuration.
  logic [DIM_BITS-1:0] w_r, h_r;
  logic [WIN_BITS-1:0] k_r;

  // Frame position counters.
  logic [POS_BITS-1:0]  cc_r, cc_nxt, rc_r, rc_nxt;
  logic [IWIN_BITS-1:0] ciw_r, ciw_nxt, riw_r, riw_nxt;
  logic [POS_BITS-1:0]  pc_r, pc_nxt, pr_r, pr_nxt;
  logic [DIM_BITS-1:0]  cbase_r, cbase_nxt, rbase_r, rbase_nxt;

  // Stage one: line memory read in flight.
  logic                         s1_valid_r, s1_first_r, s1_wlast_r;
  logic signed [PIXEL_BITS-1:0] s1_pixel_r;
  logic [AW-1:0]                s1_addr_r;
  res_meta_t                    s1_meta_r;
  logic signed [PIXEL_BITS-1:0] rd_data_r;
  logic                         fwd_hit_r;
  logic signed [PIXEL_BITS-1:0] fwd_data_r;

  logic signed [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

  logic                         in_acc, active, first, wlast;
  logic [DIM_BITS:0]            col_end, row_end, col_end2, row_end2;
  logic [AW-1:0]                addr;
  logic signed [PIXEL_BITS-1:0] prev_max, new_max;
  logic                         s1_result;
  res_meta_t                    meta;
  logic [1:0]                   oq_count;
  res_meta_t                    oq_meta;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    r = v[DIM_BITS-1:0];
    if (r == '0) begin
      r = DIM_BITS'(1);
    end else if (r > DIM_LIMIT) begin
      r = DIM_LIMIT;
    end
    return r;
  endfunction

  function automatic logic [WIN_BITS-1:0] clamp_win(input logic [CFG_BITS-1:0] v);
    logic [WIN_BITS-1:0] r;
    r = v[WIN_BITS-1:0];
    if (r == '0) begin
      r = WIN_BITS'(1);
    end else if (r > WIN_LIMIT) begin
      r = WIN_LIMIT;
    end
    return r;
  endfunction

  // Window bounds decide whether the pixel belongs to a whole window and
  // whether that window is the last one of the frame.
  always_comb begin
    col_end  = {1'b0, cbase_r} + {{(DIM_BITS-WIN_BITS+1){1'b0}}, k_r};
    row_end  = {1'b0, rbase_r} + {{(DIM_BITS-WIN_BITS+1){1'b0}}, k_r};
    col_end2 = col_end + {{(DIM_BITS-WIN_BITS+1){1'b0}}, k_r};
    row_end2 = row_end + {{(DIM_BITS-WIN_BITS+1){1'b0}}, k_r};
    active   = (col_end <= {1'b0, w_r}) && (row_end <= {1'b0, h_r}) &&
               (32'(pc_r) < MAX_WIDTH);
    first    = (ciw_r == '0) && (riw_r == '0);
    wlast    = ({1'b0, ciw_r} == k_r - 5'd1) && ({1'b0, riw_r} == k_r - 5'd1);
    addr     = AW'(pc_r);
    meta.row  = pr_r;
    meta.col  = pc_r;
    meta.last = (col_end2 > {1'b0, w_r}) && (row_end2 > {1'b0, h_r});
  end

  assign s1_result = s1_valid_r && s1_wlast_r;
  assign in_stall  = ({1'b0, oq_count} + {2'b00, s1_result}) >= OQ_FULL;
  assign in_acc    = in_valid && !in_stall;

  // Counter advance for one accepted pixel.
  always_comb begin
    cc_nxt    = cc_r + 10'd1;
    ciw_nxt   = ciw_r + 4'd1;
    pc_nxt    = pc_r;
    cbase_nxt = cbase_r;
    rc_nxt    = rc_r;
    riw_nxt   = riw_r;
    pr_nxt    = pr_r;
    rbase_nxt = rbase_r;
    if ({1'b0, ciw_r} + 5'd1 >= k_r) begin
      ciw_nxt   = '0;
      pc_nxt    = pc_r + 10'd1;
      cbase_nxt = cbase_r + {{(DIM_BITS-WIN_BITS){1'b0}}, k_r};
    end
    if ({1'b0, cc_r} + 11'd1 >= w_r) begin
      cc_nxt    = '0;
      ciw_nxt   = '0;
      pc_nxt    = '0;
      cbase_nxt = '0;
      rc_nxt    = rc_r + 10'd1;
      riw_nxt   = riw_r + 4'd1;
      if ({1'b0, riw_r} + 5'd1 >= k_r) begin
        riw_nxt   = '0;
        pr_nxt    = pr_r + 10'd1;
        rbase_nxt = rbase_r + {{(DIM_BITS-WIN_BITS){1'b0}}, k_r};
      end
      if ({1'b0, rc_r} + 11'd1 >= h_r) begin
        rc_nxt    = '0;
        riw_nxt   = '0;
        pr_nxt    = '0;
        rbase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= DIM_RESET;
      h_r     <= DIM_RESET;
      k_r     <= WIN_RESET;
      cc_r    <= '0;
      rc_r    <= '0;
      ciw_r   <= '0;
      riw_r   <= '0;
      pc_r    <= '0;
      pr_r    <= '0;
      cbase_r <= '0;
      rbase_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= clamp_dim(cfg_data);
        REG_FRAME_HEIGHT: h_r <= clamp_dim(cfg_data);
        REG_WINDOW_SIZE:  k_r <= clamp_win(cfg_data);
        default: ;
      endcase
      // Any valid register write restarts the frame.
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
          cfg_index == REG_WINDOW_SIZE) begin
        cc_r    <= '0;
        rc_r    <= '0;
        ciw_r   <= '0;
        riw_r   <= '0;
        pc_r    <= '0;
        pr_r    <= '0;
        cbase_r <= '0;
        rbase_r <= '0;
      end
    end else if (in_acc) begin
      cc_r    <= cc_nxt;
      rc_r    <= rc_nxt;
      ciw_r   <= ciw_nxt;
      riw_r   <= riw_nxt;
      pc_r    <= pc_nxt;
      pr_r    <= pr_nxt;
      cbase_r <= cbase_nxt;
      rbase_r <= rbase_nxt;
    end
  end

  // The entry written back at the same edge as a new read of that entry is
  // not yet visible in the read data, so it is carried alongside.
  assign prev_max = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign new_max  = (s1_first_r || (s1_pixel_r > prev_max)) ? s1_pixel_r : prev_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_wlast_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc && active;
      s1_wlast_r <= in_acc && active && wlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r <= first;
      s1_pixel_r <= in_pixel;
      s1_addr_r  <= addr;
      s1_meta_r  <= meta;
      fwd_hit_r  <= s1_valid_r && (s1_addr_r == addr);
      fwd_data_r <= new_max;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_mem[s1_addr_r] <= new_max;
    end
    if (in_acc && active) begin
      rd_data_r <= line_mem[addr];
    end
  end

  mp2d_ofifo #(
    .DATA_BITS (PIXEL_BITS)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_result),
    .push_data (new_max),
    .push_meta (s1_meta_r),
    .count     (oq_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_pooled_max),
    .out_meta  (oq_meta)
  );

  assign out_pool_row   = oq_meta.row;
  assign out_pool_col   = oq_meta.col;
  assign out_frame_last = oq_meta.last;

endmodule

@@ sim/max_pool_2d_stream_checker.sv @@
// ----------------------------------------------------------------------------
// max_pool_2d_stream_checker
// Watches the configuration port and both streaming channels of the max
// pooling block. It keeps its own copy of the frame counters and of the line
// of running maxima, predicts each pooled window result and compares every
// result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_checker
  import mp2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [PIXEL_BITS-1:0] out_pooled_max,
  input  logic [POS_BITS-1:0]          out_pool_row,
  input  logic [POS_BITS-1:0]          out_pool_col,
  input  logic                         out_frame_last,
  output int                           fail_count,
  output int                           results_pending,
  output int                           results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [PIXEL_BITS-1:0] value;
    res_meta_t                    meta;
  } pooled_t;

  pooled_t window_max_q[$];

  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  logic [WIN_BITS-1:0] win_reg;

  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned col_in_win;
  int unsigned row_in_win;

  logic signed [PIXEL_BITS-1:0] line_max [MAX_WIDTH];

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic int unsigned usable(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    col_in_win = 0;
    row_in_win = 0;
  endtask

  task automatic pool_pixel(input logic signed [PIXEL_BITS-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned pool_w;
    int unsigned pool_h;
    int unsigned pc;
    int unsigned pr;
    pooled_t     r;
    w      = usable(width_reg, DIM_LIMIT);
    h      = usable(height_reg, DIM_LIMIT);
    k      = usable(win_reg, WIN_LIMIT);
    pool_w = w / k;
    pool_h = h / k;
    pc     = col_pos / k;
    pr     = row_pos / k;
    // Pixels in the ragged right and bottom margins take no part.
    if (pc < pool_w && pr < pool_h && pc < MAX_WIDTH) begin
      if (row_in_win == 0 && col_in_win == 0) begin
        line_max[pc] = px;
      end else if (px > line_max[pc]) begin
        line_max[pc] = px;
      end
      if (row_in_win == k - 1 && col_in_win == k - 1) begin
        r.value     = line_max[pc];
        r.meta.row  = pr[POS_BITS-1:0];
        r.meta.col  = pc[POS_BITS-1:0];
        r.meta.last = (pr == pool_h - 1) && (pc == pool_w - 1);
        window_max_q.push_back(r);
      end
    end
    col_pos++;
    col_in_win++;
    if (col_in_win >= k) col_in_win = 0;
    if (col_pos >= w) begin
      col_pos    = 0;
      col_in_win = 0;
      row_pos++;
      row_in_win++;
      if (row_in_win >= k) row_in_win = 0;
      if (row_pos >= h) begin
        row_pos    = 0;
        row_in_win = 0;
      end
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    pooled_t want;
    if (window_max_q.size() == 0) begin
      fail_count++;
      $display("%0t: result beat with nothing expected, expected none, actual %0d at %0d/%0d",
               $time, out_pooled_max, out_pool_row, out_pool_col);
    end else begin
      want = window_max_q.pop_front();
      results_checked++;
      report_field("pooled_max", want.value, out_pooled_max);
      report_field("pool_row", want.meta.row, out_pool_row);
      report_field("pool_col", want.meta.col, out_pool_col);
      report_field("frame_last", want.meta.last, out_frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      win_reg    = WIN_RESET;
      restart_frame();
      window_max_q.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data[DIM_BITS-1:0];
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data[DIM_BITS-1:0];
            restart_frame();
          end
          REG_WINDOW_SIZE: begin
            win_reg = cfg_data[WIN_BITS-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) pool_pixel(in_pixel);
    end
    results_pending = window_max_q.size();
  end

endmodule

@@ sim/tb_max_pool_2d_stream.sv @@
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream
// Drives pixel frames through the max pooling block under a range of frame
// and window settings and idling patterns, while the checker beside the block
// predicts and compares every pooled result. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_stream import mp2d_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH    = 1024;
  localparam int PIXEL_BITS   = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PIXEL_TARGET = 1850;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [1:0]                   cfg_index = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0]          cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic signed [PIXEL_BITS-1:0] in_pixel  = '0;
  logic                         out_stall = 1'b0;

  logic                         in_stall;
  logic                         out_valid;
  logic signed [PIXEL_BITS-1:0] out_pooled_max;
  logic [POS_BITS-1:0]          out_pool_row;
  logic [POS_BITS-1:0]          out_pool_col;
  logic                         out_frame_last;

  int chk_fails;
  int chk_pending;
  int chk_results;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int pixels_sent   = 0;
  int settings_used = 0;
  int pressure_req  = 0;
  int pressure_done = 0;
  int hold_left     = 0;

  max_pool_2d_stream #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pooled_max(out_pooled_max),
    .out_pool_row  (out_pool_row),
    .out_pool_col  (out_pool_col),
    .out_frame_last(out_frame_last)
  );

  max_pool_2d_stream_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pooled_max (out_pooled_max),
    .out_pool_row   (out_pool_row),
    .out_pool_col   (out_pool_col),
    .out_frame_last (out_frame_last),
    .fail_count     (chk_fails),
    .results_pending(chk_pending),
    .results_checked(chk_results)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver side. A pressure request holds the output off for a long
  // stretch so that the result queue fills and the input stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_req != pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= pressure_req;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 68;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 68;
      end
      default: begin
        gap_pct   = 32;
        stall_pct = 32;
      end
    endcase
  endtask

  // Valid stays high from one beat to the next unless a gap is drawn.
  task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                           input logic [CFG_BITS-1:0] k);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data  <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Pixels outside any window give no result and may still be in flight,
  // so clocking goes on past the last expected beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w;
    int h;
    int k;
    int area;
    int n;
    int total_fails;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(IDLE_NONE);

    // Two 2x2 windows: one of all minimum values, one whose maximum is the
    // largest pixel and is the frame's last result.
    set_frame(4, 2, 2);
    send_pixel(16'sh8000);
    send_pixel(16'sh8000);
    send_pixel(16'sh7FFF);
    send_pixel(16'shFFFF);
    send_pixel(16'sh8000);
    send_pixel(16'sh8000);
    send_pixel(16'sh0000);
    send_pixel(16'sh0001);
    drain();

    // The window is larger than the frame, so nothing comes out.
    set_frame(3, 3, 4);
    send_pixel(16'sh5555);
    send_pixel(16'shAAAA);
    send_pixel(16'sh00FF);
    send_pixel(16'shFF00);
    send_pixel(16'sh1234);
    drain();

    // Zero in every register acts as one: each pixel is a whole frame.
    set_frame(0, 0, 0);
    send_pixel(16'sh7FFF);
    send_pixel(16'sh8000);
    send_pixel(16'sh3039);
    drain();

    // A write past the register list must not restart the frame.
    set_frame(4, 2, 2);
    send_random(3);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_random(5);
    drain();

    // Widest row with a window of one, under a long receiver hold-off.
    set_frame(11'h7FF, 0, 0);
    pressure_req++;
    send_random(MAX_WIDTH);
    drain();

    set_idling(IDLE_SENDER);
    set_frame(16, 16, 31);
    send_random(256);
    drain();

    set_idling(IDLE_RECEIVER);
    set_frame(1, 1024, 1);
    send_random(64);
    drain();

    // Small random frames, mostly whole ones; some end mid-frame so that
    // the next register write restarts the counters.
    while (pixels_sent < PIXEL_TARGET) begin
      set_idling(idling_e'(settings_used % 4));
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      k = $urandom_range(1, 4);
      case ($urandom_range(9))
        0: k = $urandom_range(5, 31);
        1: w = 0;
        2: h = 0;
        3: k = 0;
        default: ;
      endcase
      area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if ($urandom_range(3) == 0) n = $urandom_range(1, area);
      else n = area * $urandom_range(1, 2);
      set_frame(CFG_BITS'(w), CFG_BITS'(h), CFG_BITS'(k));
      send_random(n);
      drain();
    end

    total_fails = chk_fails + ((chk_pending != 0) ? 1 : 0);
    $display("Run covered %0d pixel beats under %0d frame settings, %0d pooled results compared,",
             pixels_sent, settings_used, chk_results);
    $display("with sender gaps, receiver stalls, both, none, and one long output hold-off.");
    if (total_fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
